FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the system timer.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("system timer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("system timer assertion failed");

`endif

FILE: hw/rtl/stm_pkg.sv
// Package of the system timer: transaction kinds, register indexes and the result type.
// No dependencies; core, buffer, top level, checker and testbench use its scoped names.
package stm_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_BIT = 30;

    // Transaction kinds on the command channel.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register map.
    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_OP       = 4'd1;
    localparam logic [3:0] REG_VAL_LO   = 4'd2;
    localparam logic [3:0] REG_VAL_HI   = 4'd3;
    localparam logic [3:0] REG_TGT_LO   = 4'd4;
    localparam logic [3:0] REG_TGT_HI   = 4'd5;
    localparam logic [3:0] REG_TGT_CONF = 4'd6;
    localparam logic [3:0] REG_LOAD     = 4'd7;
    localparam logic [3:0] REG_ENA      = 4'd8;
    localparam logic [3:0] REG_RAW      = 4'd9;
    localparam logic [3:0] REG_CLR      = 4'd10;
    localparam logic [3:0] REG_STATUS   = 4'd11;

    // One result transaction.
    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq;
    } t_result;

endpackage

FILE: hw/rtl/stm_cmd_if.sv
// Command channel of the system timer: tick, register read or register write.
// Depends on nothing but plain logic types.
interface stm_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, output kind, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_index, input write_data,
                    output ready);
endinterface

FILE: hw/rtl/stm_rsp_if.sv
// Response channel of the system timer: read data and the interrupt level.
// Depends on nothing but plain logic types.
interface stm_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq;

    modport source (output valid, output read_data, output irq, input ready);
    modport sink   (input valid, input read_data, input irq, output ready);
endinterface

FILE: hw/rtl/stm_core.sv
// Timer state and register file: counter, latch, comparator and interrupt bits.
// Depends on stm_pkg for register indexes, kinds and the result type.
module stm_core #(
    parameter int COUNT_WIDTH  = 52,
    parameter int PERIOD_WIDTH = 26
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_kind,
    input  logic [3:0]            i_reg_index,
    input  logic [31:0]           i_write_data,
    output stm_pkg::t_result      o_result
);

    localparam int HI_W = COUNT_WIDTH - stm_pkg::WORD_W;

    logic [COUNT_WIDTH-1:0]  r_count,   n_count;
    logic [COUNT_WIDTH-1:0]  r_latched, n_latched;
    logic                    r_lvalid,  n_lvalid;
    logic                    r_cnt_en,  n_cnt_en;
    logic                    r_cmp_en,  n_cmp_en;
    logic [COUNT_WIDTH-1:0]  r_target,  n_target;
    logic [PERIOD_WIDTH-1:0] r_period,  n_period;
    logic                    r_mode,    n_mode;
    logic [COUNT_WIDTH-1:0]  r_alarm,   n_alarm;
    logic                    r_done,    n_done;
    logic                    r_irq_en,  n_irq_en;
    logic                    r_raw,     n_raw;

    logic [COUNT_WIDTH-1:0]  period_ext;
    logic [COUNT_WIDTH-1:0]  cnt_after;
    logic [COUNT_WIDTH-1:0]  alarm_step;
    logic [COUNT_WIDTH-1:0]  load_alarm;
    logic                    hit;
    logic [31:0]             rd;

    assign period_ext = COUNT_WIDTH'(r_period);
    assign cnt_after  = r_cnt_en ? (r_count + 1'b1) : r_count;
    assign alarm_step = r_alarm + period_ext;
    assign load_alarm = r_count + period_ext;
    assign hit        = (cnt_after == r_alarm);

    always_comb begin
        n_count   = r_count;
        n_latched = r_latched;
        n_lvalid  = r_lvalid;
        n_cnt_en  = r_cnt_en;
        n_cmp_en  = r_cmp_en;
        n_target  = r_target;
        n_period  = r_period;
        n_mode    = r_mode;
        n_alarm   = r_alarm;
        n_done    = r_done;
        n_irq_en  = r_irq_en;
        n_raw     = r_raw;

        if (i_kind == stm_pkg::KIND_TICK) begin
            n_count = cnt_after;
            if (r_cmp_en) begin
                if (r_mode) begin
                    if ((r_period != '0) && hit) begin
                        n_raw   = 1'b1;
                        n_alarm = alarm_step;
                    end
                end else if (!r_done && hit) begin
                    n_raw  = 1'b1;
                    n_done = 1'b1;
                end
            end
        end else if (i_kind == stm_pkg::KIND_WRITE) begin
            case (i_reg_index)
                stm_pkg::REG_CTRL: begin
                    n_cnt_en = i_write_data[0];
                    n_cmp_en = i_write_data[1];
                end
                stm_pkg::REG_OP: begin
                    n_latched = r_count;
                    n_lvalid  = 1'b1;
                end
                stm_pkg::REG_TGT_LO: begin
                    n_target[stm_pkg::WORD_W-1:0] = i_write_data;
                end
                stm_pkg::REG_TGT_HI: begin
                    n_target[COUNT_WIDTH-1:stm_pkg::WORD_W] = i_write_data[HI_W-1:0];
                end
                stm_pkg::REG_TGT_CONF: begin
                    n_period = i_write_data[PERIOD_WIDTH-1:0];
                    n_mode   = i_write_data[stm_pkg::MODE_BIT];
                end
                stm_pkg::REG_LOAD: begin
                    if (r_mode) begin
                        n_alarm = load_alarm;
                    end else begin
                        n_alarm = r_target;
                        n_done  = 1'b0;
                    end
                end
                stm_pkg::REG_ENA: begin
                    n_irq_en = i_write_data[0];
                end
                stm_pkg::REG_CLR: begin
                    if (i_write_data[0]) begin
                        n_raw = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rd = '0;
        if (i_kind == stm_pkg::KIND_READ) begin
            case (i_reg_index)
                stm_pkg::REG_CTRL:     rd = {30'd0, r_cmp_en, r_cnt_en};
                stm_pkg::REG_OP:       rd = {30'd0, r_lvalid, 1'b0};
                stm_pkg::REG_VAL_LO:   rd = r_latched[stm_pkg::WORD_W-1:0];
                stm_pkg::REG_VAL_HI:   rd = 32'(r_latched[COUNT_WIDTH-1:stm_pkg::WORD_W]);
                stm_pkg::REG_TGT_LO:   rd = r_target[stm_pkg::WORD_W-1:0];
                stm_pkg::REG_TGT_HI:   rd = 32'(r_target[COUNT_WIDTH-1:stm_pkg::WORD_W]);
                stm_pkg::REG_TGT_CONF: rd = 32'(r_period) | (32'(r_mode) << stm_pkg::MODE_BIT);
                stm_pkg::REG_ENA:      rd = {31'd0, r_irq_en};
                stm_pkg::REG_RAW:      rd = {31'd0, r_raw};
                stm_pkg::REG_STATUS:   rd = {31'd0, r_raw & r_irq_en};
                default:               rd = '0;
            endcase
        end
    end

    assign o_result.read_data = rd;
    assign o_result.irq       = n_raw & n_irq_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_latched <= '0;
            r_lvalid  <= 1'b0;
            r_cnt_en  <= 1'b0;
            r_cmp_en  <= 1'b0;
            r_target  <= '0;
            r_period  <= '0;
            r_mode    <= 1'b0;
            r_alarm   <= '0;
            r_done    <= 1'b1;
            r_irq_en  <= 1'b0;
            r_raw     <= 1'b0;
        end else if (i_accept) begin
            r_count   <= n_count;
            r_latched <= n_latched;
            r_lvalid  <= n_lvalid;
            r_cnt_en  <= n_cnt_en;
            r_cmp_en  <= n_cmp_en;
            r_target  <= n_target;
            r_period  <= n_period;
            r_mode    <= n_mode;
            r_alarm   <= n_alarm;
            r_done    <= n_done;
            r_irq_en  <= n_irq_en;
            r_raw     <= n_raw;
        end
    end

endmodule

FILE: hw/rtl/stm_obuf.sv
// Result register with a skid entry, so one more result can enter under a stall.
// Depends on stm_pkg for the result type.
module stm_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stm_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    output stm_pkg::t_result o_result,
    input  logic             i_pop_ready
);

    logic             r_out_valid;
    stm_pkg::t_result r_out;
    logic             r_skid_valid;
    stm_pkg::t_result r_skid;
    logic             out_free;

    assign out_free = !r_out_valid || i_pop_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

FILE: hw/rtl/system_timer_with_compare_alarm_core.sv
// Channel   Direction  Payload                              Handshake
// i_cmd     in         kind, reg_index, write_data          valid/ready
// o_rsp     out        read_data, irq                       valid/ready
//
// A command transaction updates the timer state at the edge where it is accepted,
// and its response lands in the result register, or the skid entry, at that edge.
// A new command is accepted every cycle; the one-entry skid stage lets one more
// command in while a response is stalled, after which ready drops until it drains.
// Reset is synchronous and active low; the timer is usable in the first cycle after.
// The critical path is the counter increment feeding the alarm equality compare.
//
// Top level of the system timer: stm_core holds the state, stm_obuf the results.
// Depends on stm_pkg, stm_cmd_if and stm_rsp_if.
module system_timer_with_compare_alarm_core #(
    parameter int COUNT_WIDTH  = 52,
    parameter int PERIOD_WIDTH = 26
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stm_cmd_if.sink        i_cmd,
    stm_rsp_if.source      o_rsp
);

    // A command is taken whenever the skid entry is empty; the core then commits
    // its state change and hands exactly one response to the output buffer.
    logic             cmd_ready;
    logic             cmd_accept;
    stm_pkg::t_result core_result;
    stm_pkg::t_result rsp_result;

    assign i_cmd.ready = cmd_ready;
    assign cmd_accept  = i_cmd.valid && cmd_ready;

    // The core decodes the transaction: ticks advance the counter and run the
    // comparator, reads return a register, writes update the register file.
    // Its response carries the interrupt level after the transaction took effect.
    stm_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (cmd_accept),
        .i_kind       (i_cmd.kind),
        .i_reg_index  (i_cmd.reg_index),
        .i_write_data (i_cmd.write_data),
        .o_result     (core_result)
    );

    // Result register plus skid entry toward the response channel.
    stm_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cmd_accept),
        .i_result     (core_result),
        .o_ready      (cmd_ready),
        .o_valid      (o_rsp.valid),
        .o_result     (rsp_result),
        .i_pop_ready  (o_rsp.ready)
    );

    assign o_rsp.read_data = rsp_result.read_data;
    assign o_rsp.irq       = rsp_result.irq;

endmodule

FILE: hw/rtl/stm_checker.sv
// Port-level checker for the system timer, bound to the top level.
// Depends on stm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic [1:0]  i_cmd_kind,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_read_data,
    input logic        i_rsp_irq
);

    logic        cmd_acc;
    logic        rsp_stall;
    logic        pass_any;
    logic        pass_other;
    logic [32:0] rsp_word;

    assign cmd_acc    = i_cmd_valid && i_cmd_ready;
    assign rsp_stall  = i_rsp_valid && !i_rsp_ready;
    assign pass_any   = cmd_acc && !rsp_stall;
    assign pass_other = pass_any && (i_cmd_kind != stm_pkg::KIND_READ);
    assign rsp_word   = {i_rsp_read_data, i_rsp_irq};

    // A stalled response stays offered with the same payload.
    `STM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid)
    `STM_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, rsp_stall, $stable(rsp_word))

    // With nothing waiting at the output, the timer must accept commands.
    `STM_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !i_rsp_valid, i_cmd_ready)

    // A command accepted while the output drains shows up in the next cycle,
    // and only a read may carry nonzero data.
    `STM_ASSERT_NEXT(a_pass_through, i_clk, i_rst_n, pass_any, i_rsp_valid)
    `STM_ASSERT_NEXT(a_zero_unless_read, i_clk, i_rst_n, pass_other, i_rsp_read_data == '0)

endmodule

bind system_timer_with_compare_alarm_core stm_checker u_stm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_cmd_kind      (i_cmd.kind),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_data (o_rsp.read_data),
    .i_rsp_irq       (o_rsp.irq)
);

FILE: tb/system_timer_with_compare_alarm_core_tb.sv
// Testbench of the system timer core: ticks and register accesses go in on the command
// channel, and every response is checked against a transaction-level timer model.
// Depends on stm_pkg, stm_cmd_if, stm_rsp_if and system_timer_with_compare_alarm_core.
module system_timer_with_compare_alarm_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W      = 52;
    localparam int PERIOD_W     = 26;
    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int WORD_W       = stm_pkg::WORD_W;

    // A kind outside the defined three must leave the timer untouched and read as zero.
    localparam logic [1:0]  KIND_UNDEF    = 2'd3;
    // Indexes above the status register are unmapped.
    localparam logic [3:0]  REG_UNMAPPED  = 4'd15;
    localparam logic [31:0] MODE_PERIODIC = 32'h1 << stm_pkg::MODE_BIT;
    localparam logic [31:0] PERIOD_FIELD  = (32'h1 << PERIOD_W) - 1;

    // The scoreboard carries its own copy of the timer state. Each accepted command
    // transaction is applied to it in order, and the response it must produce is queued.
    class timer_scoreboard;
        logic [COUNT_W-1:0]  counter;
        logic [COUNT_W-1:0]  snapshot;
        logic [COUNT_W-1:0]  target;
        logic [COUNT_W-1:0]  alarm_at;
        logic [PERIOD_W-1:0] period;
        bit                  snapshot_valid;
        bit                  count_on;
        bit                  compare_on;
        bit                  periodic;
        bit                  oneshot_spent;
        bit                  irq_en;
        bit                  irq_raw;
        stm_pkg::t_result    due_responses[$];
        int unsigned         errors;

        function new();
            counter        = '0;
            snapshot       = '0;
            target         = '0;
            alarm_at       = '0;
            period         = '0;
            snapshot_valid = 1'b0;
            count_on       = 1'b0;
            compare_on     = 1'b0;
            periodic       = 1'b0;
            oneshot_spent  = 1'b1;
            irq_en         = 1'b0;
            irq_raw        = 1'b0;
            errors         = 0;
        endfunction

        // The comparator looks at the counter value after this tick's increment.
        function void advance();
            if (count_on) begin
                counter = counter + 1'b1;
            end
            if (!compare_on) begin
                return;
            end
            if (periodic) begin
                if (period != '0 && counter == alarm_at) begin
                    irq_raw  = 1'b1;
                    alarm_at = alarm_at + COUNT_W'(period);
                end
            end else if (!oneshot_spent && counter == alarm_at) begin
                irq_raw       = 1'b1;
                oneshot_spent = 1'b1;
            end
        endfunction

        function logic [WORD_W-1:0] register_value(logic [3:0] idx);
            case (idx)
                stm_pkg::REG_CTRL:     return {30'b0, compare_on, count_on};
                stm_pkg::REG_OP:       return {30'b0, snapshot_valid, 1'b0};
                stm_pkg::REG_VAL_LO:   return snapshot[WORD_W-1:0];
                stm_pkg::REG_VAL_HI:   return WORD_W'(snapshot[COUNT_W-1:WORD_W]);
                stm_pkg::REG_TGT_LO:   return target[WORD_W-1:0];
                stm_pkg::REG_TGT_HI:   return WORD_W'(target[COUNT_W-1:WORD_W]);
                stm_pkg::REG_TGT_CONF: begin
                    return WORD_W'(period) | (WORD_W'(periodic) << stm_pkg::MODE_BIT);
                end
                stm_pkg::REG_ENA:      return WORD_W'(irq_en);
                stm_pkg::REG_RAW:      return WORD_W'(irq_raw);
                stm_pkg::REG_STATUS:   return WORD_W'(irq_raw & irq_en);
                default:               return '0;
            endcase
        endfunction

        function void apply_write(logic [3:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                stm_pkg::REG_CTRL: begin
                    count_on   = data[0];
                    compare_on = data[1];
                end
                stm_pkg::REG_OP: begin
                    snapshot       = counter;
                    snapshot_valid = 1'b1;
                end
                stm_pkg::REG_TGT_LO:   target[WORD_W-1:0] = data;
                stm_pkg::REG_TGT_HI:   target[COUNT_W-1:WORD_W] = data[COUNT_W-WORD_W-1:0];
                stm_pkg::REG_TGT_CONF: begin
                    period   = data[PERIOD_W-1:0];
                    periodic = data[stm_pkg::MODE_BIT];
                end
                stm_pkg::REG_LOAD: begin
                    if (periodic) begin
                        alarm_at = counter + COUNT_W'(period);
                    end else begin
                        alarm_at      = target;
                        oneshot_spent = 1'b0;
                    end
                end
                stm_pkg::REG_ENA: irq_en = data[0];
                stm_pkg::REG_CLR: begin
                    if (data[0]) begin
                        irq_raw = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_command(logic [1:0] kind, logic [3:0] idx,
                                   logic [WORD_W-1:0] data);
            stm_pkg::t_result rsp;
            rsp.read_data = '0;
            case (kind)
                stm_pkg::KIND_TICK:  advance();
                stm_pkg::KIND_READ:  rsp.read_data = register_value(idx);
                stm_pkg::KIND_WRITE: apply_write(idx, data);
                default: ;
            endcase
            rsp.irq = irq_raw & irq_en;
            due_responses.push_back(rsp);
        endfunction

        function void check_response(logic [WORD_W-1:0] read_data, logic irq);
            stm_pkg::t_result want;
            if (due_responses.size() == 0) begin
                $error("response with no command outstanding: read_data %h irq %b",
                       read_data, irq);
                errors++;
                return;
            end
            want = due_responses.pop_front();
            if (read_data !== want.read_data) begin
                $error("read_data: expected %h, actual %h", want.read_data, read_data);
                errors++;
            end
            if (irq !== want.irq) begin
                $error("irq: expected %b, actual %b", want.irq, irq);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    stm_cmd_if cmd_if();
    stm_rsp_if rsp_if();

    timer_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned rsp_hold    = 0;
    int unsigned rsp_count   = 0;
    // While a calm flag is set, that side of the channel never idles.
    bit          cmd_calm    = 1'b0;
    bit          rsp_calm    = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    system_timer_with_compare_alarm_core #(
        .COUNT_WIDTH (COUNT_W),
        .PERIOD_WIDTH(PERIOD_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Response sink. After each accepted response it may hold ready low for a drawn
    // number of cycles, so the core's skid stage fills and command ready drops.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_hold = 0;
            rsp_if.ready <= 1'b0;
        end else if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_if.ready <= (rsp_hold == 0);
        end else if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (rsp_count % 48 == 0) begin
                rsp_calm = ($urandom_range(0, 2) == 0);
            end
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 15);
            rsp_if.ready <= (rsp_hold == 0);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Responses are registered in the core, so a response seen at an edge always
    // belongs to a command noted at an earlier edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.read_data, rsp_if.irq);
        end
    end

    // Drives one command transaction after a drawn idle gap and returns at the edge
    // where it is accepted. Valid stays high into the next call when that call has
    // no gap, so back-to-back transactions never lower and raise valid in one step.
    task automatic send_cmd(input logic [1:0] kind, input logic [3:0] idx,
                            input logic [31:0] data);
        int unsigned gap;
        gap = cmd_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= kind;
        cmd_if.reg_index  <= idx;
        cmd_if.write_data <= data;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        sb.note_command(kind, idx, data);
        items_sent++;
    endtask

    // Ticks carry random index and data bits, which the core must ignore.
    task automatic send_tick();
        send_cmd(stm_pkg::KIND_TICK, 4'($urandom), $urandom);
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_cmd(stm_pkg::KIND_READ, idx, $urandom);
    endtask

    task automatic send_write(input logic [3:0] idx, input logic [31:0] data);
        send_cmd(stm_pkg::KIND_WRITE, idx, data);
    endtask

    // A run of ticks, sprinkled with reads and interrupt clears.
    task automatic run_ticks(input int unsigned n);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       send_read(4'($urandom));
                1:       send_write(stm_pkg::REG_CLR, $urandom);
                default: send_tick();
            endcase
        end
    endtask

    // Holds the command side idle until every response has come back.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_responses.size() != 0);
    endtask

    initial begin
        int unsigned first_random;
        logic [31:0] period_val;

        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.kind       <= stm_pkg::KIND_TICK;
        cmd_if.reg_index  <= stm_pkg::REG_CTRL;
        cmd_if.write_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First the reset values, then counting with the comparator on.
        send_read(stm_pkg::REG_CTRL);
        send_read(stm_pkg::REG_OP);
        send_write(stm_pkg::REG_CTRL, 32'h3);
        send_write(stm_pkg::REG_ENA, 32'h1);

        // A zero period in period mode must never fire, however long it runs.
        send_write(stm_pkg::REG_TGT_CONF, MODE_PERIODIC);
        send_write(stm_pkg::REG_LOAD, '0);
        send_tick();
        send_tick();

        // A period of two fires on the second tick after the load.
        send_write(stm_pkg::REG_TGT_CONF, MODE_PERIODIC | 32'h2);
        send_write(stm_pkg::REG_LOAD, '0);
        send_tick();
        send_tick();
        send_read(stm_pkg::REG_RAW);
        send_write(stm_pkg::REG_CLR, 32'h1);
        send_read(stm_pkg::REG_STATUS);

        // One-shot mode with the widest period field: the target equals the counter
        // at load time, so the next tick has already passed it and nothing fires.
        send_write(stm_pkg::REG_TGT_CONF, ~MODE_PERIODIC);
        send_write(stm_pkg::REG_TGT_LO, sb.counter[WORD_W-1:0]);
        send_write(stm_pkg::REG_TGT_HI, '0);
        send_write(stm_pkg::REG_LOAD, '1);
        send_tick();

        // Latch the counter and read it back; the high target word keeps only its
        // implemented bits; read-only registers, an undefined kind and an unmapped
        // index change nothing.
        send_write(stm_pkg::REG_OP, '1);
        send_read(stm_pkg::REG_VAL_LO);
        send_read(stm_pkg::REG_VAL_HI);
        send_write(stm_pkg::REG_TGT_HI, '1);
        send_read(stm_pkg::REG_TGT_HI);
        send_read(stm_pkg::REG_TGT_CONF);
        send_write(stm_pkg::REG_VAL_LO, '1);
        send_cmd(KIND_UNDEF, stm_pkg::REG_CTRL, '1);
        send_read(REG_UNMAPPED);

        // Let the pipeline empty completely once before the random part.
        drain();

        // Random part: mostly armed alarms followed by ticks, with some plain register
        // traffic and some fully random transactions.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                cmd_calm = !cmd_calm;
            end
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end
            // Usually both counting and the comparator are on; sometimes anything goes.
            send_write(stm_pkg::REG_CTRL,
                       ($urandom_range(0, 4) != 0) ? ($urandom | 32'h3) : $urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // One-shot alarm a short way ahead of the counter. Now and then the
                    // high word is random, which puts the target out of reach.
                    send_write(stm_pkg::REG_TGT_CONF, $urandom & ~MODE_PERIODIC);
                    send_write(stm_pkg::REG_TGT_LO,
                               sb.counter[WORD_W-1:0] + $urandom_range(1, 24));
                    send_write(stm_pkg::REG_TGT_HI, ($urandom_range(0, 7) == 0) ? $urandom :
                               WORD_W'(sb.counter[COUNT_W-1:WORD_W]));
                    if ($urandom_range(0, 3) == 0) begin
                        send_write(stm_pkg::REG_ENA,
                                   $urandom | 32'($urandom_range(0, 3) != 0));
                    end
                    send_write(stm_pkg::REG_LOAD, $urandom);
                    run_ticks($urandom_range(4, 32));
                end
                4, 5, 6: begin
                    // Period mode, mostly with short periods so it fires repeatedly.
                    case ($urandom_range(0, 9))
                        0:       period_val = '0;
                        1:       period_val = $urandom & PERIOD_FIELD;
                        default: period_val = $urandom_range(1, 6);
                    endcase
                    send_write(stm_pkg::REG_TGT_CONF,
                               ($urandom & ~PERIOD_FIELD) | MODE_PERIODIC | period_val);
                    send_write(stm_pkg::REG_LOAD, $urandom);
                    run_ticks($urandom_range(8, 40));
                end
                7: begin
                    // Counter snapshot and plain register traffic.
                    send_write(stm_pkg::REG_OP, $urandom);
                    send_read(stm_pkg::REG_OP);
                    send_read(stm_pkg::REG_VAL_LO);
                    send_read(stm_pkg::REG_VAL_HI);
                    repeat ($urandom_range(2, 8)) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_read(4'($urandom));
                        end else begin
                            send_write(4'($urandom), $urandom);
                        end
                    end
                end
                default: begin
                    repeat ($urandom_range(3, 10)) begin
                        send_cmd(2'($urandom), 4'($urandom), $urandom);
                    end
                end
            endcase
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
